[sv/hfsrgb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hfsrgb_pkg;

  // field widths
  localparam int HALF_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int EXP_W    = 5;
  localparam int MANT_W   = 10;
  localparam int N_COLOR  = 3;

  // color channel slots
  localparam int RED_CH   = 0;
  localparam int GREEN_CH = 1;
  localparam int BLUE_CH  = 2;

  // curve table: one byte per positive half code below 1.0
  localparam int                  CURVE_AW    = 14;
  localparam int                  CURVE_DEPTH = 1 << CURVE_AW;
  localparam logic [HALF_W-1:0]   HALF_ONE    = 16'h3C00;
  localparam logic [CURVE_AW-1:0] CURVE_LAST  = 14'h3BFF;

  // clamped value as M / 2^25, M below 2^25 inside the table range
  localparam int M_W = 25;

  // multi-limb arithmetic for the exact curve test
  localparam int LIMB_W     = 32;
  localparam int N_LIMBS    = 9;
  localparam int BIG_W      = LIMB_W * N_LIMBS;
  localparam int LIMB_IDX_W = 4;
  localparam int FACTOR_W   = M_W;
  localparam int PROD_W     = LIMB_W + FACTOR_W;
  localparam int PASS_W     = 4;
  localparam int CURVE_POW  = 12;
  localparam int M_POW      = 5;
  localparam int R_SHIFT    = 125;

  localparam logic [LIMB_IDX_W-1:0] LIMB_LAST      = LIMB_IDX_W'(N_LIMBS - 1);
  localparam logic [PASS_W-1:0]     CURVE_POW_LAST = PASS_W'(CURVE_POW - 1);
  localparam logic [PASS_W-1:0]     M_POW_LAST     = PASS_W'(M_POW - 1);

  // byte k is reached when M^5 * 10761^12 >= (40k + 541)^12 * 2^125
  localparam logic [FACTOR_W-1:0] CURVE_DEN  = 25'd10761;
  localparam logic [FACTOR_W-1:0] CURVE_STEP = 25'd40;
  // offset for the next byte up: 40 * (k + 1) + 541
  localparam logic [FACTOR_W-1:0] CURVE_NEXT = 25'd581;

  // linear segment: M * 10^7 <= 31308 * 2^25 is M <= 105052
  localparam logic [M_W-1:0] LIN_M_MAX  = 25'd105052;
  localparam int             LIN_M_W    = 17;
  localparam int             LIN_NUM_W  = 37;
  localparam int             LIN_SHIFT  = 28;
  localparam int             LIN_X_W    = LIN_NUM_W - LIN_SHIFT;
  localparam logic [LIN_NUM_W-1:0] LIN_SLOPE = 37'd658920;
  localparam logic [LIN_NUM_W-1:0] LIN_BIAS  = 37'd3355443200;
  // divide by 25 as multiply by reciprocal, exact for the small range used
  localparam int                 DIV25_SHIFT = 15;
  localparam int                 LIN_Q_W     = DIV25_SHIFT + BYTE_W;
  localparam logic [LIN_Q_W-1:0] DIV25_MUL   = 23'd1311;

  // alpha: (M * 510 + 2^25) >> 26
  localparam int                 ALPHA_W     = M_W + 10;
  localparam int                 ALPHA_SHIFT = 26;
  localparam logic [ALPHA_W-1:0] ALPHA_SCALE = 35'd510;
  localparam logic [ALPHA_W-1:0] ALPHA_BIAS  = 35'd33554432;

  typedef enum logic [1:0] {
    CC_ZERO,
    CC_FULL,
    CC_CURVE
  } chan_class_t;

  typedef enum logic [3:0] {
    FS_KINIT,
    FS_KMUL,
    FS_POINT,
    FS_LIN,
    FS_RMUL,
    FS_LMUL,
    FS_CMP,
    FS_WRITE,
    FS_DONE
  } fill_state_t;

  typedef struct packed {
    logic                en;
    logic [CURVE_AW-1:0] addr;
    logic [BYTE_W-1:0]   data;
  } curve_wr_t;

  // positive finite half below 1.0 as M with c = M / 2^25
  function automatic logic [M_W-1:0] decode_m(input logic [HALF_W-1:0] h);
    logic [EXP_W-1:0] expo;
    logic [M_W-1:0]   sig;
    expo = h[HALF_W-2 -: EXP_W];
    if (expo == '0) begin
      sig = M_W'({h[MANT_W-1:0], 1'b0});
    end else begin
      sig = M_W'({1'b1, h[MANT_W-1:0]}) << expo;
    end
    return sig;
  endfunction

  // negative, negative zero and nan give zero; one or more and +inf saturate
  function automatic chan_class_t classify(input logic [HALF_W-1:0] h);
    chan_class_t cls;
    if (h[HALF_W-1]) begin
      cls = CC_ZERO;
    end else if (h[HALF_W-2 -: EXP_W] == '1 && h[MANT_W-1:0] != '0) begin
      cls = CC_ZERO;
    end else if (h >= HALF_ONE) begin
      cls = CC_FULL;
    end else begin
      cls = CC_CURVE;
    end
    return cls;
  endfunction

  function automatic logic [BYTE_W-1:0] alpha_byte(input logic [HALF_W-1:0] h);
    logic [ALPHA_W-1:0] scaled;
    logic [BYTE_W-1:0]  q;
    scaled = ALPHA_W'(decode_m(h)) * ALPHA_SCALE + ALPHA_BIAS;
    unique case (classify(h))
      CC_CURVE: q = scaled[ALPHA_SHIFT +: BYTE_W];
      CC_FULL:  q = '1;
      default:  q = '0;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

[sv/hfsrgb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module hfsrgb_ram #(
  parameter int WIDTH = hfsrgb_pkg::BYTE_W,
  parameter int DEPTH = hfsrgb_pkg::CURVE_DEPTH
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [WIDTH-1:0]         wr_data,
  input  wire                     rd_en,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/hfsrgb_fill.sv]
`timescale 1ns / 1ps
`default_nettype none

module hfsrgb_fill (
  input  wire                   clk,
  input  wire                   rst_n,
  output hfsrgb_pkg::curve_wr_t curve_wr,
  output logic                  fill_done
);

  import hfsrgb_pkg::*;

  fill_state_t state_r, state_nxt;

  logic [BIG_W-1:0]      acc_r, acc_nxt;
  logic [BIG_W-1:0]      kbig_r, kbig_nxt;
  logic [BIG_W-1:0]      rbig_r, rbig_nxt;
  logic [PASS_W-1:0]     pass_r, pass_nxt;
  logic [LIMB_IDX_W-1:0] limb_r, limb_nxt;
  logic [FACTOR_W-1:0]   carry_r, carry_nxt;
  logic [CURVE_AW-1:0]   addr_r, addr_nxt;
  logic [M_W-1:0]        m_r, m_nxt;
  logic [BYTE_W-1:0]     k_r, k_nxt;
  logic [BYTE_W-1:0]     byte_r, byte_nxt;
  logic                  r_ok_r, r_ok_nxt;
  logic                  ge_r, ge_nxt;
  logic [LIN_X_W-1:0]    x_r, x_nxt;

  logic [FACTOR_W-1:0]  factor;
  logic [PROD_W-1:0]    prod;
  logic [BIG_W-1:0]     acc_rot;
  logic                 last_limb;
  logic [M_W-1:0]       m_point;
  logic [LIN_NUM_W-1:0] lin_num;
  logic [LIN_Q_W-1:0]   lin_q;
  logic [LIMB_W-1:0]    a_limb;
  logic [LIMB_W-1:0]    b_limb;
  logic                 ge_step;

  // multiplier factor for the running product
  always_comb begin
    unique case (state_r)
      FS_KMUL: factor = CURVE_DEN;
      FS_RMUL: factor = FACTOR_W'(k_r) * CURVE_STEP + CURVE_NEXT;
      default: factor = m_r;
    endcase
  end

  // one limb times factor per cycle, number rotates through limb 0
  assign prod      = PROD_W'(acc_r[LIMB_W-1:0]) * PROD_W'(factor) + PROD_W'(carry_r);
  assign acc_rot   = {prod[LIMB_W-1:0], acc_r[BIG_W-1:LIMB_W]};
  assign last_limb = (limb_r == LIMB_LAST);

  // serial compare, low limb first
  assign a_limb  = acc_r[LIMB_W-1:0];
  assign b_limb  = rbig_r[LIMB_W-1:0];
  assign ge_step = (a_limb > b_limb) || ((a_limb == b_limb) && ge_r);

  // linear segment arithmetic
  assign m_point = decode_m(HALF_W'(addr_r));
  assign lin_num = LIN_NUM_W'(m_point[LIN_M_W-1:0]) * LIN_SLOPE + LIN_BIAS;
  assign lin_q   = LIN_Q_W'(x_r) * DIV25_MUL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_KINIT;
      addr_r  <= '0;
      k_r     <= '0;
      r_ok_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      k_r     <= k_nxt;
      r_ok_r  <= r_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    kbig_r  <= kbig_nxt;
    rbig_r  <= rbig_nxt;
    pass_r  <= pass_nxt;
    limb_r  <= limb_nxt;
    carry_r <= carry_nxt;
    m_r     <= m_nxt;
    byte_r  <= byte_nxt;
    ge_r    <= ge_nxt;
    x_r     <= x_nxt;
  end

  // sweep sequencer: one table entry per visit of FS_POINT
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    kbig_nxt  = kbig_r;
    rbig_nxt  = rbig_r;
    pass_nxt  = pass_r;
    limb_nxt  = limb_r;
    carry_nxt = carry_r;
    addr_nxt  = addr_r;
    m_nxt     = m_r;
    k_nxt     = k_r;
    byte_nxt  = byte_r;
    r_ok_nxt  = r_ok_r;
    ge_nxt    = ge_r;
    x_nxt     = x_r;
    curve_wr  = '0;
    fill_done = 1'b0;

    unique case (state_r)
      FS_KINIT: begin
        acc_nxt   = BIG_W'(1);
        pass_nxt  = '0;
        limb_nxt  = '0;
        carry_nxt = '0;
        state_nxt = FS_KMUL;
      end

      // 10761^12, computed once
      FS_KMUL: begin
        acc_nxt   = acc_rot;
        carry_nxt = prod[PROD_W-1:LIMB_W];
        limb_nxt  = limb_r + 1'b1;
        if (last_limb) begin
          limb_nxt  = '0;
          carry_nxt = '0;
          pass_nxt  = pass_r + 1'b1;
          if (pass_r == CURVE_POW_LAST) begin
            kbig_nxt  = acc_rot;
            pass_nxt  = '0;
            state_nxt = FS_POINT;
          end
        end
      end

      FS_POINT: begin
        m_nxt     = m_point;
        pass_nxt  = '0;
        limb_nxt  = '0;
        carry_nxt = '0;
        if (m_point <= LIN_M_MAX) begin
          x_nxt     = lin_num[LIN_SHIFT +: LIN_X_W];
          state_nxt = FS_LIN;
        end else if (k_r == '1) begin
          byte_nxt  = '1;
          state_nxt = FS_WRITE;
        end else if (!r_ok_r) begin
          acc_nxt   = BIG_W'(1);
          state_nxt = FS_RMUL;
        end else begin
          acc_nxt   = kbig_r;
          state_nxt = FS_LMUL;
        end
      end

      FS_LIN: begin
        byte_nxt  = lin_q[DIV25_SHIFT +: BYTE_W];
        state_nxt = FS_WRITE;
      end

      // threshold for the next byte: (40(k+1) + 541)^12 * 2^125
      FS_RMUL: begin
        acc_nxt   = acc_rot;
        carry_nxt = prod[PROD_W-1:LIMB_W];
        limb_nxt  = limb_r + 1'b1;
        if (last_limb) begin
          limb_nxt  = '0;
          carry_nxt = '0;
          pass_nxt  = pass_r + 1'b1;
          if (pass_r == CURVE_POW_LAST) begin
            rbig_nxt  = acc_rot << R_SHIFT;
            r_ok_nxt  = 1'b1;
            acc_nxt   = kbig_r;
            pass_nxt  = '0;
            state_nxt = FS_LMUL;
          end
        end
      end

      // M^5 * 10761^12
      FS_LMUL: begin
        acc_nxt   = acc_rot;
        carry_nxt = prod[PROD_W-1:LIMB_W];
        limb_nxt  = limb_r + 1'b1;
        if (last_limb) begin
          limb_nxt  = '0;
          carry_nxt = '0;
          pass_nxt  = pass_r + 1'b1;
          if (pass_r == M_POW_LAST) begin
            pass_nxt  = '0;
            ge_nxt    = 1'b1;
            state_nxt = FS_CMP;
          end
        end
      end

      FS_CMP: begin
        acc_nxt  = {a_limb, acc_r[BIG_W-1:LIMB_W]};
        rbig_nxt = {b_limb, rbig_r[BIG_W-1:LIMB_W]};
        ge_nxt   = ge_step;
        limb_nxt = limb_r + 1'b1;
        if (last_limb) begin
          limb_nxt  = '0;
          byte_nxt  = ge_step ? k_r + 1'b1 : k_r;
          state_nxt = FS_WRITE;
        end
      end

      FS_WRITE: begin
        curve_wr.en   = 1'b1;
        curve_wr.addr = addr_r;
        curve_wr.data = byte_r;
        k_nxt         = byte_r;
        if (byte_r != k_r) begin
          r_ok_nxt = 1'b0;
        end
        if (addr_r == CURVE_LAST) begin
          state_nxt = FS_DONE;
        end else begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = FS_POINT;
        end
      end

      FS_DONE: begin
        fill_done = 1'b1;
      end

      default: begin
        state_nxt = FS_KINIT;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/half_float_rgba_to_srgb8_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake            payload
// in       input      in_valid / in_ready   in_{red,green,blue,alpha}_half, 16 bit each
// out      output     out_valid / out_ready out_{red,green,blue,alpha}_byte, 8 bit each
//
// One pixel per clock after the table fill while out_ready is high; a pixel is read
// from the ram on the accepting edge, then selected into the output register.
// After reset the sequencer fills the first 15360 entries of the 16384-entry curve
// table (linear-segment entries directly, power-segment entries by a multi-limb
// power test, the threshold rebuilt at each byte step); in_ready stays low until then.
// With out_ready low, up to two pixels are held: output register and ram read stage.

module half_float_rgba_to_srgb8_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [hfsrgb_pkg::HALF_W-1:0] in_red_half,
  input  wire [hfsrgb_pkg::HALF_W-1:0] in_green_half,
  input  wire [hfsrgb_pkg::HALF_W-1:0] in_blue_half,
  input  wire [hfsrgb_pkg::HALF_W-1:0] in_alpha_half,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [hfsrgb_pkg::BYTE_W-1:0] out_red_byte,
  output logic [hfsrgb_pkg::BYTE_W-1:0] out_green_byte,
  output logic [hfsrgb_pkg::BYTE_W-1:0] out_blue_byte,
  output logic [hfsrgb_pkg::BYTE_W-1:0] out_alpha_byte
);

  import hfsrgb_pkg::*;

  curve_wr_t curve_wr;
  logic      fill_done;

  logic [HALF_W-1:0] color_half [N_COLOR];
  logic [BYTE_W-1:0] curve_byte [N_COLOR];
  logic [BYTE_W-1:0] color_byte [N_COLOR];

  logic              in_accept;
  logic              advance;
  logic              s1_valid_r;
  chan_class_t       s1_class_r [N_COLOR];
  logic [BYTE_W-1:0] s1_alpha_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_color_r [N_COLOR];
  logic [BYTE_W-1:0] out_alpha_r;

  // curve table fill after reset
  hfsrgb_fill u_fill (
    .clk       (clk),
    .rst_n     (rst_n),
    .curve_wr  (curve_wr),
    .fill_done (fill_done)
  );

  assign color_half[RED_CH]   = in_red_half;
  assign color_half[GREEN_CH] = in_green_half;
  assign color_half[BLUE_CH]  = in_blue_half;

  // one table copy per color channel, same contents
  for (genvar g = 0; g < N_COLOR; g++) begin : g_curve
    hfsrgb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CURVE_DEPTH)
    ) u_curve_ram (
      .clk     (clk),
      .wr_en   (curve_wr.en),
      .wr_addr (curve_wr.addr),
      .wr_data (curve_wr.data),
      .rd_en   (in_accept),
      .rd_addr (color_half[g][CURVE_AW-1:0]),
      .rd_data (curve_byte[g])
    );
  end

  // handshake: the read stage moves on when the output register frees up
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = fill_done && (!s1_valid_r || advance);
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // read stage side data
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < N_COLOR; i++) begin
        s1_class_r[i] <= classify(color_half[i]);
      end
      s1_alpha_r <= alpha_byte(in_alpha_half);
    end
  end

  // special cases override the table byte
  always_comb begin
    for (int i = 0; i < N_COLOR; i++) begin
      unique case (s1_class_r[i])
        CC_CURVE: color_byte[i] = curve_byte[i];
        CC_FULL:  color_byte[i] = '1;
        default:  color_byte[i] = '0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      for (int i = 0; i < N_COLOR; i++) begin
        out_color_r[i] <= color_byte[i];
      end
      out_alpha_r <= s1_alpha_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_byte   = out_color_r[RED_CH];
  assign out_green_byte = out_color_r[GREEN_CH];
  assign out_blue_byte  = out_color_r[BLUE_CH];
  assign out_alpha_byte = out_alpha_r;

endmodule

`default_nettype wire

[sv/hfsrgb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module hfsrgb_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire [hfsrgb_pkg::HALF_W-1:0] in_red_half,
  input wire [hfsrgb_pkg::HALF_W-1:0] in_green_half,
  input wire [hfsrgb_pkg::HALF_W-1:0] in_blue_half,
  input wire [hfsrgb_pkg::HALF_W-1:0] in_alpha_half,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [hfsrgb_pkg::BYTE_W-1:0] out_red_byte,
  input wire [hfsrgb_pkg::BYTE_W-1:0] out_green_byte,
  input wire [hfsrgb_pkg::BYTE_W-1:0] out_blue_byte,
  input wire [hfsrgb_pkg::BYTE_W-1:0] out_alpha_byte
);

  // stalled input holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_red_half) &&
      $stable(in_green_half) && $stable(in_blue_half) && $stable(in_alpha_half))
    else $error("stalled input transaction changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red_byte) &&
      $stable(out_green_byte) && $stable(out_blue_byte) && $stable(out_alpha_byte))
    else $error("stalled output transaction changed");

  // ready only drops behind a stalled output
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_ready) |-> out_valid && !out_ready)
    else $error("in_ready dropped without output back pressure");

  // an empty output side never blocks input once the table is ready
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(in_ready) && !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // a fresh result comes from an input transaction taken through the read stage
  a_first_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output transaction without matching input transaction");

endmodule

bind half_float_rgba_to_srgb8_top hfsrgb_checker u_checker (.*);

`default_nettype wire
